FILE: design/pcp_pkg.sv
// Shared types and constants for the point-in-convex-polygon tester.
// Used by pcp_front, pcp_back, the top level and the port checker.
`default_nettype none
package pcp_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_COORD_BITS   = 11;
    localparam int CoordMaxBits     = 16;
    localparam int UserW            = 2;
    localparam int OutTdataW        = 8;
    localparam int UserReqBit       = 0;
    localparam int UserFirstBit     = 1;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_QUERY   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [CoordMaxBits-1:0] x;
        logic [CoordMaxBits-1:0] y;
    } pcp_cmd_t;

endpackage
`default_nettype wire

FILE: design/pcp_front.sv
// Front part: accepts stream transfers, classifies them into commands and
// queues them for the back part. Depends on pcp_pkg.
`default_nettype none
module pcp_front #(
    parameter int COORD_BITS = pcp_pkg::DEF_COORD_BITS,
    localparam int TdataW = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [TdataW-1:0]           s_tdata,
    input  wire logic [pcp_pkg::UserW-1:0]   s_tuser,
    output logic                             q_valid,
    input  wire logic                        q_pop,
    output pcp_pkg::pcp_cmd_t                q_cmd
);
    import pcp_pkg::*;

    pcp_cmd_t    ent_reg [2];
    logic        wptr_reg;
    logic        rptr_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    logic        pop;
    pcp_cmd_t    in_cmd;

    always_comb
    begin
        in_cmd.x = CoordMaxBits'(s_tdata[COORD_BITS-1:0]);
        in_cmd.y = CoordMaxBits'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
        if (s_tuser[UserReqBit])
        begin
            in_cmd.kind = CMD_QUERY;
        end
        else if (s_tuser[UserFirstBit])
        begin
            in_cmd.kind = CMD_RESTART;
        end
        else
        begin
            in_cmd.kind = CMD_LOAD;
        end
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = ent_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

FILE: design/pcp_back.sv
// Back part: vertex memory, coordinate sums, and the pipelined edge walk
// that answers a query. Holds the result register. Depends on pcp_pkg.
`default_nettype none
module pcp_back #(
    parameter int MAX_VERTICES = pcp_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = pcp_pkg::DEF_COORD_BITS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    output logic                                q_pop,
    input  wire pcp_pkg::pcp_cmd_t              q_cmd,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [pcp_pkg::OutTdataW-1:0]       m_tdata
);
    import pcp_pkg::*;

    localparam int CW  = COORD_BITS;
    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int SW  = CW + NW;
    localparam int DW  = CW + 1;
    localparam int PRW = 2 * DW;
    localparam int CCW = PRW + 1;
    localparam int SPW = SW + 1 + DW;
    localparam int NCW = NW + 1 + CCW;
    localparam int GW  = NW + 2 * CW + 6;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_DRAIN = 3'b100
    } st_t;

    st_t              st_reg, st_next;
    logic [NW-1:0]    count_reg, count_next;
    logic [SW-1:0]    sumx_reg, sumx_next, sumy_reg, sumy_next;
    logic [NW-1:0]    rdcnt_reg, rdcnt_next;
    logic [CW-1:0]    px_reg, py_reg;
    logic             out_vld_reg, out_vld_next;
    logic             out_bit_reg, out_bit_next;
    logic             dec_reg, dec_next;
    logic             res_reg, res_next;

    logic [2*CW-1:0]  mem [MAX_VERTICES];
    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [CW-1:0]    cx, cy;
    logic             take_query;
    logic             rd_last;

    // pipeline stage registers
    logic             s0_vld_reg, s0_first_reg, s0_last_reg;
    logic [2*CW-1:0]  rd_data_reg;
    logic [CW-1:0]    prevx_reg, prevy_reg;
    logic             s1_vld_reg, s1_last_reg;
    logic signed [DW-1:0]  a_reg, b_reg, x0_reg, y0_reg;
    logic             s2_vld_reg, s2_last_reg;
    logic signed [PRW-1:0] ax0_reg, by0_reg, pxa_reg, pyb_reg;
    logic signed [SPW-1:0] sxa_reg, syb_reg;
    logic             s3_vld_reg, s3_last_reg;
    logic signed [CCW-1:0] c_reg;
    logic signed [GW-1:0]  p1_reg, c1_reg, c1b_reg, p_reg;
    logic             s4_vld_reg, s4_last_reg;
    logic signed [NCW-1:0] nc_reg;

    logic signed [DW-1:0]   px_s, py_s, x1_s, y1_s;
    logic signed [SW:0]     sx_s, sy_s;
    logic signed [NW:0]     n_s;
    logic signed [NCW-1:0]  nc_w;
    logic signed [GW-1:0]   cen;
    logic                   p_zero, c_zero, edge_miss, finish, final_bit;

    assign cx = q_cmd.x[CW-1:0];
    assign cy = q_cmd.y[CW-1:0];

    // control and load handling
    always_comb
    begin
        st_next      = st_reg;
        count_next   = count_reg;
        sumx_next    = sumx_reg;
        sumy_next    = sumy_reg;
        rdcnt_next   = rdcnt_reg;
        q_pop        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = count_reg[AW-1:0];
        rd_en        = 1'b0;
        rd_last      = (rdcnt_reg == count_reg);
        rd_addr      = rd_last ? '0 : rdcnt_reg[AW-1:0];
        take_query   = 1'b0;
        out_vld_next = out_vld_reg && !m_tready;
        out_bit_next = out_bit_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.kind)
                        CMD_RESTART:
                        begin
                            q_pop      = 1'b1;
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            count_next = NW'(1);
                            sumx_next  = SW'(cx);
                            sumy_next  = SW'(cy);
                        end
                        CMD_QUERY:
                        begin
                            if (!out_vld_reg || m_tready)
                            begin
                                q_pop = 1'b1;
                                if (count_reg == '0)
                                begin
                                    out_vld_next = 1'b1;
                                    out_bit_next = 1'b1;
                                end
                                else
                                begin
                                    take_query = 1'b1;
                                    rdcnt_next = '0;
                                    st_next    = ST_WALK;
                                end
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                            if (count_reg < NW'(MAX_VERTICES))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + NW'(1);
                                sumx_next  = sumx_reg + SW'(cx);
                                sumy_next  = sumy_reg + SW'(cy);
                            end
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // read vertex 0 again after the last one to close the polygon
                rd_en      = 1'b1;
                rdcnt_next = rdcnt_reg + NW'(1);
                if (rd_last)
                begin
                    st_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (finish)
                begin
                    out_vld_next = 1'b1;
                    out_bit_next = final_bit;
                    st_next      = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {cy, cx};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // edge datapath
    assign px_s = $signed({1'b0, px_reg});
    assign py_s = $signed({1'b0, py_reg});
    assign x1_s = $signed({1'b0, rd_data_reg[CW-1:0]});
    assign y1_s = $signed({1'b0, rd_data_reg[2*CW-1:CW]});
    assign sx_s = $signed({1'b0, sumx_reg});
    assign sy_s = $signed({1'b0, sumy_reg});
    assign n_s  = $signed({1'b0, count_reg});
    assign nc_w = n_s * c_reg;

    always_ff @(posedge clk)
    begin
        if (take_query)
        begin
            px_reg <= cx;
            py_reg <= cy;
        end
        if (s0_vld_reg)
        begin
            prevx_reg <= rd_data_reg[CW-1:0];
            prevy_reg <= rd_data_reg[2*CW-1:CW];
            a_reg     <= y1_s - $signed({1'b0, prevy_reg});
            b_reg     <= x1_s - $signed({1'b0, prevx_reg});
            x0_reg    <= $signed({1'b0, prevx_reg});
            y0_reg    <= $signed({1'b0, prevy_reg});
        end
        ax0_reg <= a_reg * x0_reg;
        by0_reg <= b_reg * y0_reg;
        pxa_reg <= px_s * a_reg;
        pyb_reg <= py_s * b_reg;
        sxa_reg <= sx_s * a_reg;
        syb_reg <= sy_s * b_reg;
        c_reg   <= CCW'(ax0_reg) - CCW'(by0_reg);
        p1_reg  <= GW'(pxa_reg) - GW'(pyb_reg);
        c1_reg  <= GW'(sxa_reg) - GW'(syb_reg);
        nc_reg  <= nc_w;
        p_reg   <= p1_reg - GW'(c_reg);
        c1b_reg <= c1_reg;
    end

    assign cen       = c1b_reg - GW'(nc_reg);
    assign p_zero    = (p_reg == '0);
    assign c_zero    = (cen == '0);
    assign edge_miss = !p_zero && (c_zero || (cen[GW-1] != p_reg[GW-1]));
    assign finish    = s4_vld_reg && s4_last_reg;
    assign final_bit = dec_reg ? res_reg : !edge_miss;

    always_comb
    begin
        dec_next = dec_reg;
        res_next = res_reg;
        if (take_query)
        begin
            dec_next = 1'b0;
        end
        else if (s4_vld_reg && !dec_reg && (p_zero || edge_miss))
        begin
            // first deciding edge wins
            dec_next = 1'b1;
            res_next = p_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            count_reg    <= '0;
            sumx_reg     <= '0;
            sumy_reg     <= '0;
            rdcnt_reg    <= '0;
            out_vld_reg  <= 1'b0;
            out_bit_reg  <= 1'b0;
            dec_reg      <= 1'b0;
            res_reg      <= 1'b0;
            s0_vld_reg   <= 1'b0;
            s0_first_reg <= 1'b0;
            s0_last_reg  <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s2_last_reg  <= 1'b0;
            s3_vld_reg   <= 1'b0;
            s3_last_reg  <= 1'b0;
            s4_vld_reg   <= 1'b0;
            s4_last_reg  <= 1'b0;
        end
        else
        begin
            st_reg       <= st_next;
            count_reg    <= count_next;
            sumx_reg     <= sumx_next;
            sumy_reg     <= sumy_next;
            rdcnt_reg    <= rdcnt_next;
            out_vld_reg  <= out_vld_next;
            out_bit_reg  <= out_bit_next;
            dec_reg      <= dec_next;
            res_reg      <= res_next;
            s0_vld_reg   <= rd_en;
            s0_first_reg <= rd_en && (rdcnt_reg == '0);
            s0_last_reg  <= rd_en && rd_last;
            s1_vld_reg   <= s0_vld_reg && !s0_first_reg;
            s1_last_reg  <= s0_last_reg;
            s2_vld_reg   <= s1_vld_reg;
            s2_last_reg  <= s1_last_reg;
            s3_vld_reg   <= s2_vld_reg;
            s3_last_reg  <= s2_last_reg;
            s4_vld_reg   <= s3_vld_reg;
            s4_last_reg  <= s3_last_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OutTdataW-1){1'b0}}, out_bit_reg};

endmodule
`default_nettype wire

FILE: design/point_in_convex_polygon.sv
// Top level of the point-in-convex-polygon tester.
// Instantiates pcp_front and pcp_back; depends on pcp_pkg.
//
//  channel | direction | tdata                         | tuser
//  s_*     | in        | coord_x, coord_y (low first)  | req_type, first_vertex
//  m_*     | out       | inside_res, zero padded       | none
//
// A vertex load gives no result. A query reads each vertex in turn and then
// vertex 0 again to close the polygon, then drains the five-stage pipeline
// (s0 to s4). An empty polygon answers inside without a walk. Reset clears
// counts, sums, state and valid flags, not the vertex memory. A two-entry
// queue lets the input take up to two transfers while a query runs or
// a result waits on m_tready.
`default_nettype none
module point_in_convex_polygon #(
    parameter int MAX_VERTICES = pcp_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = pcp_pkg::DEF_COORD_BITS,
    localparam int TdataW = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [TdataW-1:0]             s_tdata,  // coord_x, coord_y, zero pad
    input  wire logic [pcp_pkg::UserW-1:0]     s_tuser,  // req_type, first_vertex
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pcp_pkg::OutTdataW-1:0]      m_tdata   // inside_res, zero pad
);
    import pcp_pkg::*;

    logic      q_valid;
    logic      q_pop;
    pcp_cmd_t  q_cmd;

    pcp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    pcp_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

FILE: design/pcp_checker.sv
// Port checker for point_in_convex_polygon, attached by bind.
// Depends on pcp_pkg; sees only the top level's ports.
`default_nettype none
module pcp_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [pcp_pkg::UserW-1:0]     s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [pcp_pkg::OutTdataW-1:0] m_tdata
);
    import pcp_pkg::*;

    logic [2:0] pend_reg;
    logic       q_in;
    logic       r_out;

    assign q_in  = s_tvalid && s_tready && s_tuser[UserReqBit];
    assign r_out = m_tvalid && m_tready;

    // count queries not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_reg + {2'b0, q_in} - {2'b0, r_out};
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_owed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 3'd0)
        else $error("result without a pending query");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 3'd4 |-> !s_tready)
        else $error("more queries in flight than storage holds");

endmodule

bind point_in_convex_polygon pcp_checker u_pcp_checker (.*);
`default_nettype wire
